@@ hw/rtl/k_resource_interval_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// k_resource_interval_scheduler_defines
// Assertion macros shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef K_RESOURCE_INTERVAL_SCHEDULER_DEFINES_SVH
`define K_RESOURCE_INTERVAL_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define KRIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define KRIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/kris_pkg.sv @@
// ----------------------------------------------------------------------------
// kris_pkg
// Field widths and shared types of the interval scheduler.
// ----------------------------------------------------------------------------
package kris_pkg;

  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] MEMBER_RESET = 5'd1;

  // flags that travel with the scan token along the cell chain
  typedef struct packed {
    logic valid;
    logic best_found;
    logic fresh_found;
  } kris_scan_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic en;
    logic clr;
  } kris_wr_t;

endpackage

@@ hw/rtl/kris_if.sv @@
// ----------------------------------------------------------------------------
// kris_if
// Request and result channels of the interval scheduler.
// ----------------------------------------------------------------------------
interface kris_in_if;
  import kris_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic              last_item;

  modport source (output valid, output start_time, output end_time, output last_item,
                  input ready);
  modport sink   (input valid, input start_time, input end_time, input last_item,
                  output ready);
endinterface

interface kris_out_if;
  import kris_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [SLOT_W-1:0]  slot_used;
  logic [COUNT_W-1:0] total_accepted;

  modport source (output valid, output accepted, output slot_used, output total_accepted,
                  input ready);
  modport sink   (input valid, input accepted, input slot_used, input total_accepted,
                  output ready);
endinterface

@@ hw/rtl/kris_cell.sv @@
// ----------------------------------------------------------------------------
// kris_cell
// One resource: holds its busy-until time and in-use flag, and updates the
// scan token (best fit, first free slot, used count) on its way past.
// ----------------------------------------------------------------------------
module kris_cell #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = 32,
  parameter int IDX_BITS  = 4,
  parameter int USED_BITS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [TIME_BITS-1:0]  start,
  input  kris_pkg::kris_scan_t  scan_in,
  input  logic [TIME_BITS-1:0]  best_val_in,
  input  logic [IDX_BITS-1:0]   best_idx_in,
  input  logic [IDX_BITS-1:0]   fresh_idx_in,
  input  logic [USED_BITS-1:0]  used_in,
  output kris_pkg::kris_scan_t  scan_out,
  output logic [TIME_BITS-1:0]  best_val_out,
  output logic [IDX_BITS-1:0]   best_idx_out,
  output logic [IDX_BITS-1:0]   fresh_idx_out,
  output logic [USED_BITS-1:0]  used_out,
  input  kris_pkg::kris_wr_t    wr,
  input  logic [IDX_BITS-1:0]   wr_idx,
  input  logic [TIME_BITS-1:0]  wr_val
);
  import kris_pkg::*;

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

  logic [TIME_BITS-1:0] busy;
  logic                 in_use;
  logic                 take_best;
  logic                 take_fresh;

  // fit test: strict > keeps the lowest index on ties
  assign take_best  = in_use && (busy <= start) &&
                      (!scan_in.best_found || (busy > best_val_in));
  assign take_fresh = !in_use && !scan_in.fresh_found;

  // resource state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
    end else if (wr.clr) begin
      in_use <= 1'b0;
    end else if (wr.en && (wr_idx == MY_IDX)) begin
      in_use <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == MY_IDX)) begin
      busy <= wr_val;
    end
  end

  // token hand-off to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
    scan_out.best_found  <= scan_in.best_found | take_best;
    scan_out.fresh_found <= scan_in.fresh_found | take_fresh;
    best_val_out         <= take_best  ? busy   : best_val_in;
    best_idx_out         <= take_best  ? MY_IDX : best_idx_in;
    fresh_idx_out        <= take_fresh ? MY_IDX : fresh_idx_in;
    used_out             <= used_in + USED_BITS'(in_use);
  end

endmodule

@@ hw/rtl/k_resource_interval_scheduler.sv @@
// A request is captured and its scan token walks the cell chain one cell per cycle;
// the token is latched at the chain tail for the decision, whose result is registered.
// A new request is taken only after the decision fires; a waiting result stalls the decision.
// Reset (rst, synchronous): all resources free, count zero, member_count = 1.
// A request flagged last_item clears the resources and count after its result.
// ----------------------------------------------------------------------------
// k_resource_interval_scheduler
// Greedy interval scheduling onto up to member_count resources, built as a
// chain of resource cells scanned by a token.
// ----------------------------------------------------------------------------
`include "k_resource_interval_scheduler_defines.svh"

module k_resource_interval_scheduler #(
  parameter int MAX_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [kris_pkg::CFG_W-1:0] cfg_wdata,
  kris_in_if.sink                    intervals,
  kris_out_if.source                 results
);
  import kris_pkg::*;

  localparam int IDX_BITS  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int USED_BITS = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W     = (USED_BITS > CFG_W) ? USED_BITS : CFG_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]           state;
  logic [CFG_W-1:0]     member_count;
  logic                 launch;
  logic [TIME_BITS-1:0] start_q;
  logic [TIME_BITS-1:0] end_q;
  logic                 last_q;

  // token chain
  kris_scan_t           scan    [0:MAX_SLOTS];
  logic [TIME_BITS-1:0] best_val[0:MAX_SLOTS];
  logic [IDX_BITS-1:0]  best_idx[0:MAX_SLOTS];
  logic [IDX_BITS-1:0]  fresh_idx[0:MAX_SLOTS];
  logic [USED_BITS-1:0] used    [0:MAX_SLOTS];

  // captured token at the chain tail
  logic                 dec_best_found;
  logic                 dec_fresh_found;
  logic [IDX_BITS-1:0]  dec_best_idx;
  logic [IDX_BITS-1:0]  dec_fresh_idx;
  logic [USED_BITS-1:0] dec_used;

  logic                 fresh_ok;
  logic                 take;
  logic [IDX_BITS-1:0]  take_idx;
  logic                 fire;
  kris_wr_t             wr;

  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;

  logic                 out_valid;
  logic                 out_accepted;
  logic [SLOT_W-1:0]    out_slot;
  logic [COUNT_W-1:0]   out_total;

  assign intervals.ready = (state == ST_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      member_count <= MEMBER_RESET;
    end else if (cfg_we) begin
      member_count <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (intervals.valid && intervals.ready) begin
      start_q <= TIME_BITS'(intervals.start_time);
      end_q   <= TIME_BITS'(intervals.end_time);
      last_q  <= intervals.last_item;
    end
  end

  // chain head: empty token
  assign scan[0].valid       = launch;
  assign scan[0].best_found  = 1'b0;
  assign scan[0].fresh_found = 1'b0;
  assign best_val[0]         = '0;
  assign best_idx[0]         = '0;
  assign fresh_idx[0]        = '0;
  assign used[0]             = '0;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    kris_cell #(
      .IDX       (i),
      .TIME_BITS (TIME_BITS),
      .IDX_BITS  (IDX_BITS),
      .USED_BITS (USED_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .start         (start_q),
      .scan_in       (scan[i]),
      .best_val_in   (best_val[i]),
      .best_idx_in   (best_idx[i]),
      .fresh_idx_in  (fresh_idx[i]),
      .used_in       (used[i]),
      .scan_out      (scan[i+1]),
      .best_val_out  (best_val[i+1]),
      .best_idx_out  (best_idx[i+1]),
      .fresh_idx_out (fresh_idx[i+1]),
      .used_out      (used[i+1]),
      .wr            (wr),
      .wr_idx        (take_idx),
      .wr_val        (end_q)
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (intervals.valid) begin
            state  <= ST_SCAN;
            launch <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (scan[MAX_SLOTS].valid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // latch the finished token
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scan[MAX_SLOTS].valid) begin
      dec_best_found  <= scan[MAX_SLOTS].best_found;
      dec_fresh_found <= scan[MAX_SLOTS].fresh_found;
      dec_best_idx    <= best_idx[MAX_SLOTS];
      dec_fresh_idx   <= fresh_idx[MAX_SLOTS];
      dec_used        <= used[MAX_SLOTS];
    end
  end

  // decision: best fit first, else open a fresh slot within the limit
  assign fresh_ok = dec_fresh_found && (CMP_W'(dec_used) < CMP_W'(member_count));
  assign take     = dec_best_found || fresh_ok;
  assign take_idx = dec_best_found ? dec_best_idx : dec_fresh_idx;
  assign fire     = (state == ST_DECIDE) && (!out_valid || results.ready);
  assign wr.en    = fire && take;
  assign wr.clr   = fire && last_q;

  // saturating accept count
  assign count_next = (take && (count != '1)) ? count + 1'b1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= last_q ? '0 : count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_accepted <= take;
      out_slot     <= take ? SLOT_W'(take_idx) : '0;
      out_total    <= count_next;
    end
  end

  assign results.valid          = out_valid;
  assign results.accepted       = out_accepted;
  assign results.slot_used      = out_slot;
  assign results.total_accepted = out_total;

  // checks
  `KRIS_ASSERT_NEXT(a_accept_launches, intervals.valid && intervals.ready, (state == ST_SCAN) && launch, "accepted request did not launch a scan")
  `KRIS_ASSERT_NOW(a_tail_in_scan, scan[MAX_SLOTS].valid, state == ST_SCAN, "scan token arrived outside a scan")
  `KRIS_ASSERT_NOW(a_reject_slot_zero, results.valid && !results.accepted, results.slot_used == '0, "rejected result carries a slot")
  `KRIS_ASSERT_NEXT(a_accept_counts, fire && take, results.valid && (results.total_accepted != '0), "accepted result with zero total")

endmodule
